// ===== rtl/weighted_index_sampler_top_macros.svh =====
// Assertion macros shared by the weighted index sampler RTL.
// Self-contained; the assertions compile away when SYNTHESIS is defined.
`ifndef WEIGHTED_INDEX_SAMPLER_TOP_MACROS_SVH
`define WEIGHTED_INDEX_SAMPLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define WIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("weighted index sampler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("weighted index sampler assertion failed");

`else

`define WIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define WIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/wis_pkg.sv =====
// Package for the weighted index sampler: sizes, function codes, queue item type.
// No dependencies.
package wis_pkg;

	localparam int unsigned MAX_ENTRIES = 4096;
	localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W       = IDX_W + 1;
	localparam int unsigned SUM_W       = 44;
	localparam int unsigned WGT_W       = 32;
	localparam int unsigned FRAC_W      = 32;
	localparam int unsigned FUNC_W      = 2;
	localparam int unsigned PROD_W      = SUM_W - FRAC_W + FRAC_W;
	localparam int unsigned LOPROD_W    = 2 * FRAC_W;

	localparam logic [SUM_W-1:0] SUM_MAX  = '1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

	// Function codes on the request channel; the fourth code is ignored.
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = QPTR_W + 1;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_SAMPLE
	} wis_op_t;

	typedef struct packed {
		wis_op_t            op;
		logic [WGT_W-1:0]   weight;
		logic [FRAC_W-1:0]  frac;
	} wis_item_t;

	// Head of the command queue as the back end sees it.
	typedef struct packed {
		logic      valid;
		wis_item_t item;
	} wis_head_t;

endpackage

// ===== rtl/wis_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module wis_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/wis_front.sv =====
// Front end: accepts request transfers, decodes the function and queues commands.
// Depends on wis_pkg.
module wis_front
	import wis_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [WGT_W-1:0]  weight,
	input  logic [FRAC_W-1:0] random_fraction,
	output wis_head_t         head,
	input  logic              pop
);

	wis_item_t          slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  fill_q;
	logic               accept;
	logic               push;
	wis_item_t          item_in;

	assign req_stall = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign accept    = req_valid && !req_stall;

	// The unused function code is taken and dropped here.
	always_comb begin
		item_in.weight = weight;
		item_in.frac   = random_fraction;
		item_in.op     = OP_CLEAR;
		push           = 1'b0;
		unique case (func)
			FUNC_CLEAR: begin
				item_in.op = OP_CLEAR;
				push       = accept;
			end
			FUNC_APPEND: begin
				item_in.op = OP_APPEND;
				push       = accept;
			end
			FUNC_SAMPLE: begin
				item_in.op = OP_SAMPLE;
				push       = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign head.valid = (fill_q != '0);
	assign head.item  = slots_q[rd_ptr_q];

endmodule

// ===== rtl/wis_back.sv =====
// Back end: executes clear, append and draw commands against the running-sum table.
// Depends on wis_pkg, wis_ram and the assertion macro header.
`include "weighted_index_sampler_top_macros.svh"

module wis_back
	import wis_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  wis_head_t        head,
	output logic             pop,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [IDX_W-1:0] chosen_index,
	output logic             status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_START,
		ST_SEARCH
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     total_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     index_q;
	logic                 status_q;

	logic [FRAC_W-1:0]    frac_q;
	logic [PROD_W-1:0]    prod_hi_q;
	logic [LOPROD_W-1:0]  prod_lo_q;
	logic [SUM_W-1:0]     target_q;
	logic [IDX_W-1:0]     lo_q;
	logic [IDX_W-1:0]     hi_q;
	logic [IDX_W-1:0]     mid_q;

	logic                 out_free;
	logic                 full;
	logic                 empty;
	logic [SUM_W:0]       sum_ext;
	logic [SUM_W-1:0]     sum_sat;
	logic [PROD_W-1:0]    mul_hi;
	logic [LOPROD_W-1:0]  mul_lo;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_addr;
	logic [SUM_W-1:0]     ram_rdata;
	logic                 rd_gt;
	logic [IDX_W-1:0]     n_lo;
	logic [IDX_W-1:0]     n_hi;
	logic [IDX_W-1:0]     n_mid;
	logic                 more;
	logic                 in_search;
	logic                 out_load;

	assign out_free = !out_valid_q || !rsp_stall;
	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0) || (total_q == '0);

	// A draw is taken only when the result register will be free at its end.
	assign pop = (state_q == ST_IDLE) && head.valid &&
		((head.item.op != OP_SAMPLE) || out_free);

	assign sum_ext = {1'b0, total_q} + (SUM_W + 1)'(head.item.weight);
	assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

	// Split product: upper bits of the total and lower bits, each times the fraction.
	assign mul_hi = total_q[SUM_W-1:FRAC_W] * frac_q;
	assign mul_lo = total_q[FRAC_W-1:0] * frac_q;

	// One search step per cycle: fold in the compare, then issue the next probe.
	assign rd_gt = (ram_rdata > target_q);

	always_comb begin
		n_lo = lo_q;
		n_hi = hi_q;
		if (state_q == ST_SEARCH) begin
			if (rd_gt) begin
				n_hi = mid_q;
			end else begin
				n_lo = mid_q + 1'b1;
			end
		end
	end

	assign n_mid = n_lo + ((n_hi - n_lo) >> 1);
	assign more  = (n_lo < n_hi);

	// A result is loaded by an error draw at dequeue or by the last search step.
	assign in_search = (state_q == ST_START) || (state_q == ST_SEARCH);
	assign out_load  = (pop && (head.item.op == OP_SAMPLE) && empty) || (in_search && !more);

	assign ram_we   = pop && (head.item.op == OP_APPEND) && !full;
	assign ram_addr = ram_we ? count_q[IDX_W-1:0] : n_mid;

	wis_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_ENTRIES)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (sum_sat),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			index_q     <= '0;
			status_q    <= STATUS_OK;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					if (pop) begin
						unique case (head.item.op)
							OP_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							OP_APPEND: begin
								if (!full) begin
									total_q <= sum_sat;
									count_q <= count_q + 1'b1;
								end
							end
							OP_SAMPLE: begin
								if (empty) begin
									index_q  <= '0;
									status_q <= STATUS_ERR;
								end else begin
									state_q <= ST_MUL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_START;
				end
				ST_START, ST_SEARCH: begin
					if (more) begin
						state_q <= ST_SEARCH;
					end else begin
						index_q  <= n_lo;
						status_q <= STATUS_OK;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frac_q <= head.item.frac;
		end
		case (state_q) inside
			ST_MUL: begin
				prod_hi_q <= mul_hi;
				prod_lo_q <= mul_lo;
			end
			ST_ADD: begin
				target_q <= prod_hi_q + SUM_W'(prod_lo_q[LOPROD_W-1:FRAC_W]);
				lo_q     <= '0;
				hi_q     <= count_q[IDX_W-1:0] - 1'b1;
			end
			ST_START, ST_SEARCH: begin
				lo_q  <= n_lo;
				hi_q  <= n_hi;
				mid_q <= n_mid;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid    = out_valid_q;
	assign chosen_index = index_q;
	assign status       = status_q;

	`WIS_ASSERT_IMPLIES(a_err_index_zero, clk, arst_n, out_valid_q && (status_q == STATUS_ERR), index_q == '0)
	`WIS_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`WIS_ASSERT_IMPLIES(a_empty_total, clk, arst_n, count_q == '0, total_q == '0)
	`WIS_ASSERT_IMPLIES(a_search_window, clk, arst_n, state_q == ST_SEARCH, lo_q < hi_q)
	`WIS_ASSERT_NEXT(a_search_ends_in_result, clk, arst_n, in_search, (state_q == ST_SEARCH) || out_valid_q)

endmodule

// ===== rtl/weighted_index_sampler_top.sv =====
// Top level of the weighted index sampler: front end, command queue and back end.
// Depends on wis_pkg, wis_front and wis_back.
//
//   Channel   Handshake              Payload
//   req       req_valid, req_stall   func, weight, random_fraction
//   rsp       rsp_valid, rsp_stall   chosen_index, status
//
// A clear or an append is carried out as it leaves the queue. A draw leaves the
// queue, forms its target with a split multiply and then an add, issues the
// first probe, then takes binary-search steps, each bound by the registered
// read of the single-port running-sum memory.
// Reset clears the entry count, the total, the queue and the result register;
// the running-sum memory needs no clearing pass since only written entries are read.
// A stalled response holds the next draw at the head of the queue, so commands
// behind it wait as well; the four-entry queue keeps taking requests until it fills.
module weighted_index_sampler_top
	import wis_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [FUNC_W-1:0] func,
	input  logic [WGT_W-1:0]  weight,
	input  logic [FRAC_W-1:0] random_fraction,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [IDX_W-1:0]  chosen_index,
	output logic              status
);

	// Head of the command queue and the back end's dequeue strobe.
	wis_head_t head;
	logic      pop;

	// The front end takes every request transfer the queue has room for. The
	// unused function code is taken and dropped there, so it never reaches
	// the back end and produces no response.
	wis_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.func            (func),
		.weight          (weight),
		.random_fraction (random_fraction),
		.head            (head),
		.pop             (pop)
	);

	// The back end owns the running-sum memory, the entry count and the total.
	// A draw scales the random fraction by the total and binary-searches for
	// the first running sum above that target; its response waits in an
	// output register that the consumer drains through rsp_stall.
	wis_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.chosen_index (chosen_index),
		.status       (status)
	);

endmodule
